// ===== sv/rssd_pkg.sv =====
package rssd_pkg;

	// field widths
	localparam int SAMPLE_W  = 24;
	localparam int RES_W     = 57;
	localparam int CFG_W     = 9;
	localparam int SQ_W      = 2 * SAMPLE_W;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 64;

	// window length minimum and reset value
	localparam int LEN_MIN   = 2;
	localparam int LEN_RESET = 10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV_LOAD,
		ST_DIV,
		ST_PASS,
		ST_DONE
	} state_t;

endpackage

// ===== sv/rolling_sum_sq_deviation.sv =====
// channel   dir  signals                        contents
// s_axis    in   s_tvalid s_tready s_tdata      sample[23:0]
//                s_tuser                        start_of_series[0]
// m_axis    out  m_tvalid m_tready m_tdata      deviation_sq_sum[56:0], zero above
//                m_tuser                        window_full[0]
// cfg       in   cfg_valid cfg_ready cfg_data   window_len[8:0]
//
// once the window is full an item goes through the update, the bit-serial mean divider
// and the single squaring multiplier walking the ring one entry per cycle; the result
// then loads when the output register is free; while filling the divider and pass are skipped
// arst_n clears the sequencer, the running total, fill count and write slot; the ring
// holds no reset and its data is only used at entries written in the current series
// the output register lets the next item in while a result waits on m_tready
module rolling_sum_sq_deviation
	import rssd_pkg::*;
#(
	parameter int WINDOW_MAX = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // sample[23:0]
	input  logic [0:0]           s_tuser,   // start_of_series[0]
	// result output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // deviation_sq_sum[56:0], zero fill above
	output logic [0:0]           m_tuser,   // window_full[0]
	// window length register
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IDX_W   = $clog2(WINDOW_MAX);
	localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
	localparam int TOTAL_W = SAMPLE_W + IDX_W;
	localparam int ACC_W   = SQ_W + IDX_W;
	localparam int CW      = (CFG_W > LEN_W) ? CFG_W : LEN_W;
	localparam int DCNT_W  = $clog2(TOTAL_W);
	localparam int LEN_RST = (LEN_RESET > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET;

	state_t state_q, state_d;

	// history state
	logic [LEN_W-1:0]           len_q;
	logic [LEN_W-1:0]           fill_q;
	logic [IDX_W-1:0]           wslot_q;
	logic signed [TOTAL_W-1:0]  total_q;

	// item being worked on
	logic [IDX_W-1:0]           slot_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic                       full_q;

	// sample ring, read data registered
	logic [SAMPLE_W-1:0]        ring [WINDOW_MAX];
	logic [SAMPLE_W-1:0]        rd_data_q;
	logic [IDX_W-1:0]           rd_addr;

	// divider
	logic [TOTAL_W-1:0]         dq_q;
	logic [LEN_W-1:0]           rem_q;
	logic [DCNT_W-1:0]          div_cnt_q;
	logic                       neg_q;
	logic [SAMPLE_W-1:0]        mean_q;

	// squaring pass
	logic [LEN_W-1:0]           pass_cnt_q;
	logic                       v1_q, v2_s2, v3_s3;
	logic [SAMPLE_W-1:0]        mag_s2;
	logic [SQ_W-1:0]            prod_s3;
	logic [ACC_W-1:0]           acc_q;

	// output register
	logic                       m_tvalid_q;
	logic [RES_W-1:0]           res_q;
	logic                       res_full_q;

	// control
	logic ring_we, issue, out_load, cfg_we, in_acc;

	// ------------------------------------------------------------------
	// combinational helpers
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]          slot_in;
	logic                      full_before, full_after;
	logic [LEN_W-1:0]          fill_inc;
	logic [LEN_W-1:0]          slot_inc;
	logic [CW-1:0]             cfg_wide;
	logic [LEN_W-1:0]          cfg_len;
	logic [TOTAL_W-1:0]        total_mag;
	logic [LEN_W:0]            rem_sh;
	logic                      div_ge;
	logic [LEN_W-1:0]          rem_next;
	logic [TOTAL_W-1:0]        dq_next;
	logic                      div_last;
	logic                      pass_end;
	logic [SAMPLE_W:0]         diff;
	logic [SAMPLE_W:0]         diff_mag;
	logic [SQ_W-1:0]           sq;
	logic [RES_W-1:0]          res_sat;
	logic signed [TOTAL_W-1:0] old_ext, new_ext;

	// a new series, or a stale write slot beyond a shorter window, wraps to the start
	always_comb begin
		if (s_tuser[0] || (LEN_W'(wslot_q) >= len_q)) begin
			slot_in = '0;
		end else begin
			slot_in = wslot_q;
		end
	end

	assign full_before = (fill_q >= len_q);
	assign fill_inc    = fill_q + LEN_W'(1);
	assign full_after  = full_before || (fill_inc >= len_q);
	assign slot_inc    = LEN_W'(slot_q) + LEN_W'(1);

	assign old_ext = {{(TOTAL_W-SAMPLE_W){rd_data_q[SAMPLE_W-1]}}, rd_data_q};
	assign new_ext = {{(TOTAL_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};

	// clamp the written length into [LEN_MIN, WINDOW_MAX]
	always_comb begin
		cfg_wide = CW'(cfg_data);
		priority if (cfg_wide < CW'(LEN_MIN)) begin
			cfg_len = LEN_W'(LEN_MIN);
		end else if (cfg_wide > CW'(WINDOW_MAX)) begin
			cfg_len = LEN_W'(WINDOW_MAX);
		end else begin
			cfg_len = LEN_W'(cfg_wide);
		end
	end

	// restoring division of |total| by len, one quotient bit per cycle
	assign total_mag = total_q[TOTAL_W-1] ? (~total_q + TOTAL_W'(1)) : total_q;
	assign rem_sh    = {rem_q, dq_q[TOTAL_W-1]};
	assign div_ge    = (rem_sh >= {1'b0, len_q});
	assign rem_next  = div_ge ? LEN_W'(rem_sh - {1'b0, len_q}) : LEN_W'(rem_sh);
	assign dq_next   = {dq_q[TOTAL_W-2:0], div_ge};
	assign div_last  = (div_cnt_q == DCNT_W'(TOTAL_W - 1));

	// pass over ring entries 0 .. len-1, pipeline drained before finishing
	assign pass_end = (pass_cnt_q == len_q) && !v1_q && !v2_s2 && !v3_s3;

	// |sample - mean| fits the sample width
	assign diff     = {rd_data_q[SAMPLE_W-1], rd_data_q} - {mean_q[SAMPLE_W-1], mean_q};
	assign diff_mag = diff[SAMPLE_W] ? (~diff + (SAMPLE_W+1)'(1)) : diff;
	assign sq       = mag_s2 * mag_s2;

	generate
		if (ACC_W > RES_W) begin : g_sat
			assign res_sat = (|acc_q[ACC_W-1:RES_W]) ? '1 : acc_q[RES_W-1:0];
		end else begin : g_nosat
			assign res_sat = RES_W'(acc_q);
		end
	endgenerate

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!cfg_valid && s_tvalid) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = full_after ? ST_DIV_LOAD : ST_DONE;
			end
			ST_DIV_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_PASS;
				end
			end
			ST_PASS: begin
				if (pass_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		cfg_ready = 1'b0;
		ring_we   = 1'b0;
		issue     = 1'b0;
		out_load  = 1'b0;
		rd_addr   = slot_q;
		unique case (state_q)
			ST_IDLE: begin
				// config has priority; the old entry at the write slot is read on accept
				cfg_ready = 1'b1;
				s_tready  = !cfg_valid;
				rd_addr   = slot_in;
			end
			ST_UPDATE: begin
				ring_we = 1'b1;
			end
			ST_PASS: begin
				issue   = (pass_cnt_q < len_q);
				rd_addr = pass_cnt_q[IDX_W-1:0];
			end
			ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
			end
		endcase
	end

	assign cfg_we = cfg_valid && cfg_ready;
	assign in_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// history: length, fill count, write slot, running total
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_W'(LEN_RST);
			fill_q  <= '0;
			wslot_q <= '0;
			total_q <= '0;
		end else if (cfg_we) begin
			len_q   <= cfg_len;
			fill_q  <= '0;
			wslot_q <= '0;
			total_q <= '0;
		end else if (in_acc && s_tuser[0]) begin
			// new series drops the history before this item
			fill_q  <= '0;
			wslot_q <= '0;
			total_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			total_q <= total_q - (full_before ? old_ext : '0) + new_ext;
			fill_q  <= full_before ? len_q : fill_inc;
			wslot_q <= (slot_inc >= len_q) ? '0 : IDX_W'(slot_inc);
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_q   <= slot_in;
			sample_q <= s_tdata[SAMPLE_W-1:0];
		end
		if (state_q == ST_UPDATE) begin
			full_q <= full_after;
		end
	end

	// sample ring
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[slot_q] <= sample_q;
		end
		rd_data_q <= ring[rd_addr];
	end

	// ------------------------------------------------------------------
	// mean divider
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_LOAD) begin
			dq_q      <= total_mag;
			rem_q     <= '0;
			div_cnt_q <= '0;
			neg_q     <= total_q[TOTAL_W-1];
		end else if (state_q == ST_DIV) begin
			dq_q      <= dq_next;
			rem_q     <= rem_next;
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
			if (div_last) begin
				// quotient truncated toward zero, sign put back
				mean_q <= neg_q ? SAMPLE_W'(~dq_next + TOTAL_W'(1)) : SAMPLE_W'(dq_next);
			end
		end
	end

	// ------------------------------------------------------------------
	// squaring pass: read, subtract mean, square, accumulate
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q  <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			v1_q  <= issue;
			v2_s2 <= v1_q;
			v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_LOAD) begin
			pass_cnt_q <= '0;
			acc_q      <= '0;
		end else begin
			if (issue) begin
				pass_cnt_q <= pass_cnt_q + LEN_W'(1);
			end
			if (v3_s3) begin
				acc_q <= acc_q + ACC_W'(prod_s3);
			end
		end
		if (v1_q) begin
			mag_s2 <= diff_mag[SAMPLE_W-1:0];
		end
		if (v2_s2) begin
			prod_s3 <= sq;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q      <= full_q ? res_sat : '0;
			res_full_q <= full_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(res_q);
	assign m_tuser  = res_full_q;

`ifndef SYNTHESIS
	// fill count never runs past the window
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_q)
		else $error("fill count above window length");

	// write slot stays inside the window after each update
	a_slot_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (LEN_W'(wslot_q) < len_q))
		else $error("write slot outside window");

	// accumulator only takes products while the pass runs
	a_pass_only: assert property (@(posedge clk) disable iff (!arst_n)
		v3_s3 |-> (state_q == ST_PASS))
		else $error("squaring pipeline active outside pass");

	// a new result never overwrites one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> (m_tvalid_q && $stable(res_q)))
		else $error("pending result overwritten");
`endif

endmodule
